[design/obmm_pkg.sv]
// Shared types and constants for the offset-binary byte matrix multiply.
// No dependencies; every other file in the design imports this package.
package obmm_pkg;

    localparam int STORE_AW    = 14;
    localparam int STORE_DEPTH = 1 << STORE_AW;
    localparam int ACC_W       = 32;
    localparam int SUM_W       = 24;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [8:0]       BYTE_OFFSET = 9'sd127;
    localparam logic signed [ACC_W-1:0] SUM_MAX     = 32'sd8388607;
    localparam logic signed [ACC_W-1:0] SUM_MIN     = -32'sd8388608;

    // configuration register indexes
    localparam logic [1:0] CFG_ROWS  = 2'd0;
    localparam logic [1:0] CFG_INNER = 2'd1;
    localparam logic [1:0] CFG_COLS  = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE_A = 2'd0,
        OP_WRITE_B = 2'd1,
        OP_COMPUTE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CMD_WRITE_A = 2'd0,
        CMD_WRITE_B = 2'd1,
        CMD_DOT     = 2'd2,
        CMD_REJECT  = 2'd3
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [STORE_AW-1:0] addr;      // write address, or first A address
        logic [7:0]          value;
        logic [STORE_AW-1:0] b_addr;    // first B address
        logic [6:0]          b_stride;  // columns in use
        logic [8:0]          count;     // inner length in use
    } cmd_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] count;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_RUN   = 2'd1,
        BK_DRAIN = 2'd2,
        BK_DONE  = 2'd3
    } bk_state_t;

endpackage

[design/obmm_front.sv]
// Front end: configuration registers, range checks and address setup.
// Turns each accepted request into a command for the queue. Uses obmm_pkg.
module obmm_front #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 256,
    parameter int MAX_COLS  = 64
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [8:0]    cfg_data,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [39:0]   s_tdata,
    input  logic [1:0]    s_tuser,
    input  logic          q_full,
    output logic          q_push,
    output obmm_pkg::cmd_t q_cmd
);
    import obmm_pkg::*;

    logic [6:0]  rows_reg, rows_next;
    logic [8:0]  inner_reg, inner_next;
    logic [6:0]  cols_reg, cols_next;

    logic [13:0] elem_index;
    logic [7:0]  elem_value;
    logic [5:0]  out_row;
    logic [5:0]  out_col;

    logic [6:0]  m_use;
    logic [8:0]  k_use;
    logic [6:0]  n_use;
    logic [15:0] limit_a;
    logic [15:0] limit_b;
    logic [14:0] a_base;
    logic        rc_ok;

    assign elem_index = s_tdata[13:0];
    assign elem_value = s_tdata[21:14];
    assign out_row    = s_tdata[27:22];
    assign out_col    = s_tdata[33:28];

    assign cfg_ready = 1'b1;

    always_comb begin
        rows_next  = rows_reg;
        inner_next = inner_reg;
        cols_next  = cols_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ROWS:  rows_next  = cfg_data[6:0];
                CFG_INNER: inner_next = cfg_data;
                CFG_COLS:  cols_next  = cfg_data[6:0];
                default:   ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= 7'd64;
            inner_reg <= 9'd256;
            cols_reg  <= 7'd64;
        end else begin
            rows_reg  <= rows_next;
            inner_reg <= inner_next;
            cols_reg  <= cols_next;
        end
    end

    // sizes above the build limits act as the limit
    assign m_use = (32'(rows_reg)  > MAX_ROWS)  ? 7'(MAX_ROWS)  : rows_reg;
    assign k_use = (32'(inner_reg) > MAX_INNER) ? 9'(MAX_INNER) : inner_reg;
    assign n_use = (32'(cols_reg)  > MAX_COLS)  ? 7'(MAX_COLS)  : cols_reg;

    assign limit_a = 16'(m_use) * 16'(k_use);
    assign limit_b = 16'(k_use) * 16'(n_use);
    assign a_base  = 15'(out_row) * 15'(k_use);
    assign rc_ok   = ({1'b0, out_row} < m_use) && ({1'b0, out_col} < n_use);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_cmd.kind     = CMD_REJECT;
        q_cmd.addr     = elem_index;
        q_cmd.value    = elem_value;
        q_cmd.b_addr   = STORE_AW'(out_col);
        q_cmd.b_stride = n_use;
        q_cmd.count    = k_use;
        case (s_tuser)
            OP_WRITE_A: begin
                if ({2'b00, elem_index} < limit_a) q_cmd.kind = CMD_WRITE_A;
            end
            OP_WRITE_B: begin
                if ({2'b00, elem_index} < limit_b) q_cmd.kind = CMD_WRITE_B;
            end
            OP_COMPUTE: begin
                q_cmd.addr = a_base[STORE_AW-1:0];
                if (rc_ok) q_cmd.kind = CMD_DOT;
            end
            default: q_cmd.kind = CMD_REJECT;
        endcase
    end

endmodule

[design/obmm_queue.sv]
// Two-entry command queue between the front end and the back end.
// Holds obmm_pkg::cmd_t entries in arrival order.
module obmm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  obmm_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output obmm_pkg::cmd_t        head_cmd,
    output obmm_pkg::q_status_t   stat
);
    import obmm_pkg::*;

    cmd_t                entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;
    assign head_cmd   = entry_reg[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[design/obmm_back.sv]
// Back end: the two byte stores, the multiply-accumulate pipeline and the
// result register. Executes commands from obmm_queue; uses obmm_pkg.
module obmm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  obmm_pkg::cmd_t      head_cmd,
    input  obmm_pkg::q_status_t q_stat,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [23:0]         m_tdata,
    output logic                m_tuser
);
    import obmm_pkg::*;

    logic [7:0] store_a [STORE_DEPTH];
    logic [7:0] store_b [STORE_DEPTH];

    bk_state_t state_reg, state_next;

    logic [STORE_AW-1:0] a_addr_reg, a_addr_next;
    logic [STORE_AW-1:0] b_addr_reg, b_addr_next;
    logic [6:0]          stride_reg, stride_next;
    logic [8:0]          count_reg, count_next;

    logic                rd_v_reg;
    logic [7:0]          rd_a_reg;
    logic [7:0]          rd_b_reg;
    logic                prod_v_reg;
    logic signed [17:0]  prod_reg;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    logic                out_valid_reg, out_valid_next;
    logic [SUM_W-1:0]    out_sum_reg, out_sum_next;
    logic                out_status_reg, out_status_next;

    logic                out_free;
    logic                start;
    logic                issue;
    logic                wr_a_en;
    logic                wr_b_en;
    logic                out_load;
    logic [SUM_W-1:0]    out_load_sum;
    logic                out_load_status;
    logic                pipe_empty;
    logic [SUM_W-1:0]    sat_sum;
    logic signed [8:0]   a_dec;
    logic signed [8:0]   b_dec;

    assign out_free   = !out_valid_reg || m_tready;
    assign pipe_empty = !rd_v_reg && !prod_v_reg;

    always_comb begin
        if (acc_reg > SUM_MAX) begin
            sat_sum = SUM_MAX[SUM_W-1:0];
        end else if (acc_reg < SUM_MIN) begin
            sat_sum = SUM_MIN[SUM_W-1:0];
        end else begin
            sat_sum = acc_reg[SUM_W-1:0];
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty && head_cmd.kind == CMD_DOT) begin
                    state_next = (head_cmd.count == '0) ? BK_DRAIN : BK_RUN;
                end
            end
            BK_RUN: begin
                if (count_reg == 9'd1) state_next = BK_DRAIN;
            end
            BK_DRAIN: begin
                if (pipe_empty) state_next = BK_DONE;
            end
            BK_DONE: begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        q_pop           = 1'b0;
        start           = 1'b0;
        issue           = 1'b0;
        wr_a_en         = 1'b0;
        wr_b_en         = 1'b0;
        out_load        = 1'b0;
        out_load_sum    = '0;
        out_load_status = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    case (head_cmd.kind)
                        CMD_DOT: begin
                            q_pop = 1'b1;
                            start = 1'b1;
                        end
                        CMD_WRITE_A: begin
                            q_pop    = out_free;
                            wr_a_en  = out_free;
                            out_load = out_free;
                        end
                        CMD_WRITE_B: begin
                            q_pop    = out_free;
                            wr_b_en  = out_free;
                            out_load = out_free;
                        end
                        default: begin
                            q_pop           = out_free;
                            out_load        = out_free;
                            out_load_status = 1'b1;
                        end
                    endcase
                end
            end
            BK_RUN: issue = 1'b1;
            BK_DRAIN: ;
            BK_DONE: begin
                out_load     = out_free;
                out_load_sum = sat_sum;
            end
            default: ;
        endcase
    end

    // address walk and accumulator
    always_comb begin
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        stride_next = stride_reg;
        count_next  = count_reg;
        acc_next    = acc_reg;
        if (start) begin
            a_addr_next = head_cmd.addr;
            b_addr_next = head_cmd.b_addr;
            stride_next = head_cmd.b_stride;
            count_next  = head_cmd.count;
            acc_next    = '0;
        end else begin
            if (issue) begin
                a_addr_next = a_addr_reg + 1'b1;
                b_addr_next = b_addr_reg + STORE_AW'(stride_reg);
                count_next  = count_reg - 1'b1;
            end
            if (prod_v_reg) acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_sum_next    = out_sum_reg;
        out_status_next = out_status_reg;
        if (out_load) begin
            out_valid_next  = 1'b1;
            out_sum_next    = out_load_sum;
            out_status_next = out_load_status;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign a_dec = signed'({1'b0, rd_a_reg}) - BYTE_OFFSET;
    assign b_dec = signed'({1'b0, rd_b_reg}) - BYTE_OFFSET;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            rd_v_reg      <= 1'b0;
            prod_v_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rd_v_reg      <= issue;
            prod_v_reg    <= rd_v_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_addr_reg     <= a_addr_next;
        b_addr_reg     <= b_addr_next;
        stride_reg     <= stride_next;
        count_reg      <= count_next;
        acc_reg        <= acc_next;
        prod_reg       <= a_dec * b_dec;
        out_sum_reg    <= out_sum_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_a_en) store_a[head_cmd.addr] <= head_cmd.value;
        rd_a_reg <= store_a[a_addr_reg];
    end

    always_ff @(posedge aclk) begin
        if (wr_b_en) store_b[head_cmd.addr] <= head_cmd.value;
        rd_b_reg <= store_b[b_addr_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sum_reg;
    assign m_tuser  = out_status_reg;

endmodule

[design/offset_byte_matrix_multiply.sv]
// Top level of the offset-binary byte matrix multiply.
// Ties obmm_front, obmm_queue and obmm_back together; uses obmm_pkg.
//
//   channel   direction  ports            carries
//   cfg       in         cfg_*            register index, value
//   s         in         s_t*             load or compute request
//   m         out        m_t*             dot sum and status
//
// Load and rejected requests stream through the back end at one per cycle
// while the result register is free. A compute request holds the back end
// for a start step, then one store read and one multiply-accumulate per
// cycle over K (the inner size in use), then a drain of the read and
// multiply registers, and then the load of the result.
// The two-entry queue keeps s_tready up while a compute runs until it fills.
// Reset clears control state only; the stores keep whatever they held.
module offset_byte_matrix_multiply #(
    parameter int MAX_ROWS  = 64,
    parameter int MAX_INNER = 256,
    parameter int MAX_COLS  = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // elem_index[13:0], elem_value[21:14],
                                   // out_row[27:22], out_col[33:28], zero pad
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // dot_sum[23:0]
    output logic        m_tuser    // status[0]
);
    import obmm_pkg::*;

    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      q_push;
    logic      q_pop;
    q_status_t q_stat;

    obmm_front #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_full    (q_stat.full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    obmm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .stat     (q_stat)
    );

    obmm_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // an error result never carries a sum
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result with nonzero sum");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && !q_pop && !q_stat.empty |=> !q_stat.empty && q_stat.count != '0)
        else $error("queue lost an entry");

endmodule
